// ----- src/online_bridge_counter_macros.svh -----
// ---------------------------------------------------------------------------
// online_bridge_counter_macros: assertion macros for the bridge counter
// ---------------------------------------------------------------------------
`ifndef ONLINE_BRIDGE_COUNTER_MACROS_SVH
`define ONLINE_BRIDGE_COUNTER_MACROS_SVH
`ifndef SYNTHESIS
// checked property, off while reset is low
`define OBC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("obc assertion failed");
// checked property, also during reset
`define OBC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("obc assertion failed");
`else
`define OBC_ASSERT(lbl, clk, rstn, prop)
`define OBC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- src/obc_pkg.sv -----
// ---------------------------------------------------------------------------
// obc_pkg: shared types and constants of the online bridge counter
// Datapath operation codes and the status bundle returned to the controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package obc_pkg;

  localparam int EP_W   = 10;  // endpoint field width
  localparam int CNT_W  = 10;  // bridge_count field width
  localparam int VC_W   = 11;  // vertex_count register width
  localparam int STAMP_W = 32;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_VERTEX_COUNT = 1'b0;  // register index, paddr[2]
  localparam logic [VC_W-1:0] VC_RESET = 11'd1024;

  typedef enum logic [5:0] {
    OP_NOP,
    OP_CLR,
    OP_VCLR,
    OP_LOAD,
    OP_RESULT,
    OP_A0,
    OP_F_RD,
    OP_F_STEP,
    OP_F_CRD,
    OP_F_CWR,
    OP_A1,
    OP_B1,
    OP_C_RD,
    OP_C_STEP,
    OP_C_BACK,
    OP_CA,
    OP_CB,
    OP_L0,
    OP_L1,
    OP_L2,
    OP_R0,
    OP_R1,
    OP_R2,
    OP_R3,
    OP_R4,
    OP_R5,
    OP_R6,
    OP_L3,
    OP_L4,
    OP_M0,
    OP_MFA,
    OP_M2A,
    OP_M3A,
    OP_M4A,
    OP_MFB,
    OP_M2B,
    OP_M3B,
    OP_M4B,
    OP_MI,
    OP_PA_RD,
    OP_PA_WR,
    OP_PB_RD,
    OP_PB_WR
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic in_bad;
    logic f_root;
    logic f_done;
    logic c_root;
    logic fr_eq_ea;
    logic cr_eq_ca;
    logic rv_nil;
    logic fp_nil;
    logic clr_last;
    logic stamp_wrap;
    logic ma_nil;
    logic mb_nil;
    logic hit;
    logic ia_end;
    logic ib_end;
    logic pa_meet;
    logic pb_meet;
    logic out_free;
  } status_t;

endpackage

// ----- src/obc_dp.sv -----
// ---------------------------------------------------------------------------
// obc_dp: datapath of the online bridge counter
// Vertex stores, working registers and the result register, driven by one
// operation code per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module obc_dp #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  obc_pkg::cmd_t               cmd_i,
  output obc_pkg::status_t            st_o,
  input  logic [obc_pkg::VC_W-1:0]    vertex_count_i,
  input  logic [obc_pkg::EP_W-1:0]    endpoint_a_i,
  input  logic [obc_pkg::EP_W-1:0]    endpoint_b_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [obc_pkg::CNT_W-1:0]   bridge_count_o,
  output logic                        bad_vertex_o
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = VW + 1;
  localparam int VCW = obc_pkg::VC_W;
  localparam int LW = (NW > VCW) ? NW : VCW;
  localparam int OW = obc_pkg::CNT_W;
  localparam int SW = obc_pkg::STAMP_W;
  localparam logic [NW-1:0] NIL = NW'(MAX_VERTICES);
  localparam logic [VW-1:0] LAST = VW'(MAX_VERTICES - 1);

  // stores
  logic [VW-1:0] bl_mem [MAX_VERTICES];
  logic [VW-1:0] cl_mem [MAX_VERTICES];
  logic [NW-1:0] fp_mem [MAX_VERTICES];
  logic [NW-1:0] cs_mem [MAX_VERTICES];
  logic [SW-1:0] vs_mem [MAX_VERTICES];
  logic [VW-1:0] pa_mem [MAX_VERTICES];
  logic [VW-1:0] pb_mem [MAX_VERTICES];

  logic          bl_we, cl_we, fp_we, cs_we, vs_we, pa_we, pb_we;
  logic [VW-1:0] bl_wa, cl_wa, fp_wa, cs_wa, vs_wa, pa_wa, pb_wa;
  logic [VW-1:0] bl_ra, cl_ra, fp_ra, cs_ra, vs_ra, pa_ra, pb_ra;
  logic [VW-1:0] bl_wd, cl_wd, pa_wd, pb_wd;
  logic [NW-1:0] fp_wd, cs_wd;
  logic [SW-1:0] vs_wd;
  logic [VW-1:0] bl_rd, cl_rd, pa_rd, pb_rd;
  logic [NW-1:0] fp_rd, cs_rd;
  logic [SW-1:0] vs_rd;

  // working registers
  logic [VW-1:0] ea_q, ea_d, eb_q, eb_d, fv_q, fv_d, fr_q, fr_d;
  logic [VW-1:0] cr_q, cr_d, ca_q, ca_d, cb_q, cb_d, rroot_q, rroot_d;
  logic [VW-1:0] meet_q, meet_d, clr_q, clr_d, bridges_q, bridges_d;
  logic [NW-1:0] rv_q, rv_d, rchild_q, rchild_d, rp_q, rp_d;
  logic [NW-1:0] ma_q, ma_d, mb_q, mb_d, la_q, la_d, lb_q, lb_d, i_q, i_d;
  logic [NW-1:0] tmp_q, tmp_d;
  logic [SW-1:0] stamp_q, stamp_d;
  logic          bad_q, bad_d, out_valid_q, out_valid_d, out_bad_q, out_bad_d;
  logic [OW-1:0] out_count_q, out_count_d;

  logic [LW-1:0] a_ext, b_ext, vc_ext, lim;
  logic          in_bad;

  assign a_ext  = LW'(endpoint_a_i);
  assign b_ext  = LW'(endpoint_b_i);
  assign vc_ext = LW'(vertex_count_i);
  assign lim    = (vc_ext >= LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES) : vc_ext;
  assign in_bad = (a_ext >= lim) || (b_ext >= lim);

  always_ff @(posedge clk_i) begin
    if (bl_we) bl_mem[bl_wa] <= bl_wd;
    bl_rd <= bl_mem[bl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cl_we) cl_mem[cl_wa] <= cl_wd;
    cl_rd <= cl_mem[cl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fp_we) fp_mem[fp_wa] <= fp_wd;
    fp_rd <= fp_mem[fp_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cs_we) cs_mem[cs_wa] <= cs_wd;
    cs_rd <= cs_mem[cs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (vs_we) vs_mem[vs_wa] <= vs_wd;
    vs_rd <= vs_mem[vs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pa_we) pa_mem[pa_wa] <= pa_wd;
    pa_rd <= pa_mem[pa_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pb_we) pb_mem[pb_wa] <= pb_wd;
    pb_rd <= pb_mem[pb_ra];
  end

  always_comb begin
    bl_we = 1'b0; cl_we = 1'b0; fp_we = 1'b0; cs_we = 1'b0;
    vs_we = 1'b0; pa_we = 1'b0; pb_we = 1'b0;
    bl_wa = '0; cl_wa = '0; fp_wa = '0; cs_wa = '0; vs_wa = '0; pa_wa = '0; pb_wa = '0;
    bl_ra = '0; cl_ra = '0; fp_ra = '0; cs_ra = '0; vs_ra = '0; pa_ra = '0; pb_ra = '0;
    bl_wd = '0; cl_wd = '0; pa_wd = '0; pb_wd = '0;
    fp_wd = '0; cs_wd = '0; vs_wd = '0;
    ea_d = ea_q; eb_d = eb_q; fv_d = fv_q; fr_d = fr_q;
    cr_d = cr_q; ca_d = ca_q; cb_d = cb_q; rroot_d = rroot_q;
    meet_d = meet_q; clr_d = clr_q; bridges_d = bridges_q;
    rv_d = rv_q; rchild_d = rchild_q; rp_d = rp_q;
    ma_d = ma_q; mb_d = mb_q; la_d = la_q; lb_d = lb_q; i_d = i_q;
    tmp_d = tmp_q; stamp_d = stamp_q; bad_d = bad_q;
    out_count_d = out_count_q; out_bad_d = out_bad_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (cmd_i.op)
      obc_pkg::OP_CLR: begin
        bl_we = 1'b1; bl_wa = clr_q; bl_wd = clr_q;
        cl_we = 1'b1; cl_wa = clr_q; cl_wd = clr_q;
        fp_we = 1'b1; fp_wa = clr_q; fp_wd = NIL;
        cs_we = 1'b1; cs_wa = clr_q; cs_wd = NW'(1);
        vs_we = 1'b1; vs_wa = clr_q; vs_wd = '0;
        clr_d = (clr_q == LAST) ? '0 : clr_q + VW'(1);
      end
      obc_pkg::OP_VCLR: begin
        vs_we = 1'b1; vs_wa = clr_q; vs_wd = '0;
        clr_d = (clr_q == LAST) ? '0 : clr_q + VW'(1);
        if (clr_q == LAST) stamp_d = SW'(1);
      end
      obc_pkg::OP_LOAD: begin
        ea_d  = VW'(a_ext);
        eb_d  = VW'(b_ext);
        bad_d = in_bad;
      end
      obc_pkg::OP_RESULT: begin
        out_count_d = OW'(bridges_q);
        out_bad_d   = bad_q;
        out_valid_d = 1'b1;
      end
      obc_pkg::OP_A0: begin
        fv_d = ea_q; fr_d = ea_q;
      end
      obc_pkg::OP_F_RD: bl_ra = fr_q;
      obc_pkg::OP_F_STEP: begin
        if (bl_rd != fr_q) fr_d = bl_rd;
      end
      obc_pkg::OP_F_CRD: bl_ra = fv_q;
      obc_pkg::OP_F_CWR: begin
        // path compression: point the visited entry at the root
        bl_we = 1'b1; bl_wa = fv_q; bl_wd = fr_q;
        fv_d = bl_rd;
      end
      obc_pkg::OP_A1: begin
        ea_d = fr_q; fv_d = eb_q; fr_d = eb_q;
      end
      obc_pkg::OP_B1: begin
        eb_d = fr_q; cr_d = ea_q;
      end
      obc_pkg::OP_C_RD: cl_ra = cr_q;
      obc_pkg::OP_C_STEP: begin
        fv_d = cl_rd; fr_d = cl_rd;
      end
      obc_pkg::OP_C_BACK: cr_d = fr_q;
      obc_pkg::OP_CA: begin
        ca_d = cr_q; cr_d = eb_q;
      end
      obc_pkg::OP_CB: cb_d = cr_q;
      obc_pkg::OP_L0: begin
        bridges_d = bridges_q + VW'(1);
        cs_ra = ca_q;
      end
      obc_pkg::OP_L1: begin
        tmp_d = cs_rd; cs_ra = cb_q;
      end
      obc_pkg::OP_L2: begin
        // smaller component is the one re-rooted
        if (tmp_q > cs_rd) begin
          ea_d = eb_q; eb_d = ea_q; ca_d = cb_q; cb_d = ca_q;
        end
      end
      obc_pkg::OP_R0: begin
        rv_d = {1'b0, ea_q}; rroot_d = ea_q; rchild_d = NIL;
      end
      obc_pkg::OP_R1: fp_ra = rv_q[VW-1:0];
      obc_pkg::OP_R2: begin
        rp_d = fp_rd; fv_d = fp_rd[VW-1:0]; fr_d = fp_rd[VW-1:0];
      end
      obc_pkg::OP_R3: rp_d = {1'b0, fr_q};
      obc_pkg::OP_R4: begin
        fp_we = 1'b1; fp_wa = rv_q[VW-1:0]; fp_wd = rchild_q;
        cl_we = 1'b1; cl_wa = rv_q[VW-1:0]; cl_wd = rroot_q;
        rchild_d = rv_q; rv_d = rp_q;
      end
      obc_pkg::OP_R5: cs_ra = rchild_q[VW-1:0];
      obc_pkg::OP_R6: begin
        cs_we = 1'b1; cs_wa = rroot_q; cs_wd = cs_rd;
        tmp_d = cs_rd;
      end
      obc_pkg::OP_L3: begin
        fp_we = 1'b1; fp_wa = ea_q; fp_wd = {1'b0, eb_q};
        cl_we = 1'b1; cl_wa = ea_q; cl_wd = eb_q;
        cs_ra = cb_q;
      end
      obc_pkg::OP_L4: begin
        cs_we = 1'b1; cs_wa = cb_q; cs_wd = cs_rd + tmp_q;
      end
      obc_pkg::OP_M0: begin
        stamp_d = stamp_q + SW'(1);
        ma_d = {1'b0, ea_q}; mb_d = {1'b0, eb_q};
        la_d = '0; lb_d = '0;
      end
      obc_pkg::OP_MFA: begin
        fv_d = ma_q[VW-1:0]; fr_d = ma_q[VW-1:0];
      end
      obc_pkg::OP_M2A: begin
        ma_d = {1'b0, fr_q};
        pa_we = 1'b1; pa_wa = la_q[VW-1:0]; pa_wd = fr_q;
        la_d = la_q + NW'(1);
        vs_ra = fr_q;
      end
      obc_pkg::OP_M3A: begin
        if (vs_rd == stamp_q) begin
          meet_d = ma_q[VW-1:0];
        end else begin
          vs_we = 1'b1; vs_wa = ma_q[VW-1:0]; vs_wd = stamp_q;
        end
        fp_ra = ma_q[VW-1:0];
      end
      obc_pkg::OP_M4A: ma_d = fp_rd;
      obc_pkg::OP_MFB: begin
        fv_d = mb_q[VW-1:0]; fr_d = mb_q[VW-1:0];
      end
      obc_pkg::OP_M2B: begin
        mb_d = {1'b0, fr_q};
        pb_we = 1'b1; pb_wa = lb_q[VW-1:0]; pb_wd = fr_q;
        lb_d = lb_q + NW'(1);
        vs_ra = fr_q;
      end
      obc_pkg::OP_M3B: begin
        if (vs_rd == stamp_q) begin
          meet_d = mb_q[VW-1:0];
        end else begin
          vs_we = 1'b1; vs_wa = mb_q[VW-1:0]; vs_wd = stamp_q;
        end
        fp_ra = mb_q[VW-1:0];
      end
      obc_pkg::OP_M4B: mb_d = fp_rd;
      obc_pkg::OP_MI: i_d = '0;
      obc_pkg::OP_PA_RD: pa_ra = i_q[VW-1:0];
      obc_pkg::OP_PA_WR: begin
        bl_we = 1'b1; bl_wa = pa_rd; bl_wd = meet_q;
        if (pa_rd != meet_q) begin
          if (bridges_q != '0) bridges_d = bridges_q - VW'(1);
          i_d = i_q + NW'(1);
        end
      end
      obc_pkg::OP_PB_RD: pb_ra = i_q[VW-1:0];
      obc_pkg::OP_PB_WR: begin
        bl_we = 1'b1; bl_wa = pb_rd; bl_wd = meet_q;
        if (pb_rd != meet_q) begin
          if (bridges_q != '0) bridges_d = bridges_q - VW'(1);
          i_d = i_q + NW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      bridges_q   <= '0;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      bridges_q   <= bridges_d;
      stamp_q     <= stamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ea_q <= ea_d; eb_q <= eb_d; fv_q <= fv_d; fr_q <= fr_d;
    cr_q <= cr_d; ca_q <= ca_d; cb_q <= cb_d; rroot_q <= rroot_d;
    meet_q <= meet_d; rv_q <= rv_d; rchild_q <= rchild_d; rp_q <= rp_d;
    ma_q <= ma_d; mb_q <= mb_d; la_q <= la_d; lb_q <= lb_d; i_q <= i_d;
    tmp_q <= tmp_d; bad_q <= bad_d;
    out_count_q <= out_count_d; out_bad_q <= out_bad_d;
  end

  always_comb begin
    st_o.in_bad     = in_bad;
    st_o.f_root     = (bl_rd == fr_q);
    st_o.f_done     = (fv_q == fr_q);
    st_o.c_root     = (cl_rd == cr_q);
    st_o.fr_eq_ea   = (fr_q == ea_q);
    st_o.cr_eq_ca   = (cr_q == ca_q);
    st_o.rv_nil     = (rv_q == NIL);
    st_o.fp_nil     = (fp_rd == NIL);
    st_o.clr_last   = (clr_q == LAST);
    st_o.stamp_wrap = &stamp_q;
    st_o.ma_nil     = (ma_q == NIL);
    st_o.mb_nil     = (mb_q == NIL);
    st_o.hit        = (vs_rd == stamp_q);
    st_o.ia_end     = (i_q == la_q);
    st_o.ib_end     = (i_q == lb_q);
    st_o.pa_meet    = (pa_rd == meet_q);
    st_o.pb_meet    = (pb_rd == meet_q);
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign bridge_count_o = out_count_q;
  assign bad_vertex_o   = out_bad_q;

endmodule

// ----- src/obc_ctrl.sv -----
// ---------------------------------------------------------------------------
// obc_ctrl: sequencer of the online bridge counter
// One-hot state machine with a return register for the shared find walk.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module obc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  obc_pkg::status_t st_i,
  output obc_pkg::cmd_t    cmd_o
);

  localparam int NS = 43;

  typedef enum logic [NS-1:0] {
    S_CLEAR = NS'(1) << 0,  S_IDLE  = NS'(1) << 1,  S_A0    = NS'(1) << 2,
    S_A1    = NS'(1) << 3,  S_B1    = NS'(1) << 4,  S_FRD   = NS'(1) << 5,
    S_FCHK  = NS'(1) << 6,  S_FCRD  = NS'(1) << 7,  S_FCWR  = NS'(1) << 8,
    S_CRD   = NS'(1) << 9,  S_CCHK  = NS'(1) << 10, S_CBACK = NS'(1) << 11,
    S_CA    = NS'(1) << 12, S_CB    = NS'(1) << 13, S_L0    = NS'(1) << 14,
    S_L1    = NS'(1) << 15, S_L2    = NS'(1) << 16, S_R0    = NS'(1) << 17,
    S_R1    = NS'(1) << 18, S_R2    = NS'(1) << 19, S_R3    = NS'(1) << 20,
    S_R4    = NS'(1) << 21, S_R5    = NS'(1) << 22, S_R6    = NS'(1) << 23,
    S_L3    = NS'(1) << 24, S_L4    = NS'(1) << 25, S_M0    = NS'(1) << 26,
    S_VCLR  = NS'(1) << 27, S_M1    = NS'(1) << 28, S_M2    = NS'(1) << 29,
    S_M3    = NS'(1) << 30, S_M4    = NS'(1) << 31, S_M5    = NS'(1) << 32,
    S_M6    = NS'(1) << 33, S_M7    = NS'(1) << 34, S_M8    = NS'(1) << 35,
    S_MI    = NS'(1) << 36, S_MA1   = NS'(1) << 37, S_MA2   = NS'(1) << 38,
    S_MJ    = NS'(1) << 39, S_MB1   = NS'(1) << 40, S_MB2   = NS'(1) << 41,
    S_DONE  = NS'(1) << 42
  } state_e;

  state_e state_q, state_d, ret_q, ret_d, cret_q, cret_d;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    cret_d     = cret_q;
    cmd_o.op   = obc_pkg::OP_NOP;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = obc_pkg::OP_CLR;
        if (st_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = obc_pkg::OP_LOAD;
          state_d  = st_i.in_bad ? S_DONE : S_A0;
        end
      end
      S_A0: begin
        cmd_o.op = obc_pkg::OP_A0;
        ret_d = S_A1; state_d = S_FRD;
      end
      // find walk: root search, then compression pass, then return
      S_FRD: begin
        cmd_o.op = obc_pkg::OP_F_RD; state_d = S_FCHK;
      end
      S_FCHK: begin
        cmd_o.op = obc_pkg::OP_F_STEP;
        state_d = st_i.f_root ? S_FCRD : S_FRD;
      end
      S_FCRD: begin
        if (st_i.f_done) begin
          state_d = ret_q;
        end else begin
          cmd_o.op = obc_pkg::OP_F_CRD; state_d = S_FCWR;
        end
      end
      S_FCWR: begin
        cmd_o.op = obc_pkg::OP_F_CWR; state_d = S_FCRD;
      end
      S_A1: begin
        cmd_o.op = obc_pkg::OP_A1;
        ret_d = S_B1; state_d = S_FRD;
      end
      S_B1: begin
        if (st_i.fr_eq_ea) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = obc_pkg::OP_B1;
          cret_d = S_CA; state_d = S_CRD;
        end
      end
      // component root walk over component leaders
      S_CRD: begin
        cmd_o.op = obc_pkg::OP_C_RD; state_d = S_CCHK;
      end
      S_CCHK: begin
        if (st_i.c_root) begin
          state_d = cret_q;
        end else begin
          cmd_o.op = obc_pkg::OP_C_STEP;
          ret_d = S_CBACK; state_d = S_FRD;
        end
      end
      S_CBACK: begin
        cmd_o.op = obc_pkg::OP_C_BACK; state_d = S_CRD;
      end
      S_CA: begin
        cmd_o.op = obc_pkg::OP_CA;
        cret_d = S_CB; state_d = S_CRD;
      end
      S_CB: begin
        cmd_o.op = obc_pkg::OP_CB;
        state_d = st_i.cr_eq_ca ? S_M0 : S_L0;
      end
      S_L0: begin cmd_o.op = obc_pkg::OP_L0; state_d = S_L1; end
      S_L1: begin cmd_o.op = obc_pkg::OP_L1; state_d = S_L2; end
      S_L2: begin cmd_o.op = obc_pkg::OP_L2; state_d = S_R0; end
      S_R0: begin cmd_o.op = obc_pkg::OP_R0; state_d = S_R1; end
      S_R1: begin
        if (st_i.rv_nil) begin
          state_d = S_R5;
        end else begin
          cmd_o.op = obc_pkg::OP_R1; state_d = S_R2;
        end
      end
      S_R2: begin
        cmd_o.op = obc_pkg::OP_R2;
        if (st_i.fp_nil) begin
          state_d = S_R4;
        end else begin
          ret_d = S_R3; state_d = S_FRD;
        end
      end
      S_R3: begin cmd_o.op = obc_pkg::OP_R3; state_d = S_R4; end
      S_R4: begin cmd_o.op = obc_pkg::OP_R4; state_d = S_R1; end
      S_R5: begin cmd_o.op = obc_pkg::OP_R5; state_d = S_R6; end
      S_R6: begin cmd_o.op = obc_pkg::OP_R6; state_d = S_L3; end
      S_L3: begin cmd_o.op = obc_pkg::OP_L3; state_d = S_L4; end
      S_L4: begin cmd_o.op = obc_pkg::OP_L4; state_d = S_DONE; end
      S_M0: begin
        cmd_o.op = obc_pkg::OP_M0;
        state_d = st_i.stamp_wrap ? S_VCLR : S_M1;
      end
      S_VCLR: begin
        cmd_o.op = obc_pkg::OP_VCLR;
        if (st_i.clr_last) state_d = S_M1;
      end
      // alternate steps up both forest paths until a stamp hit or both ends
      S_M1: begin
        priority if (st_i.ma_nil && st_i.mb_nil) begin
          state_d = S_DONE;
        end else if (!st_i.ma_nil) begin
          cmd_o.op = obc_pkg::OP_MFA;
          ret_d = S_M2; state_d = S_FRD;
        end else begin
          state_d = S_M5;
        end
      end
      S_M2: begin cmd_o.op = obc_pkg::OP_M2A; state_d = S_M3; end
      S_M3: begin
        cmd_o.op = obc_pkg::OP_M3A;
        state_d = st_i.hit ? S_MI : S_M4;
      end
      S_M4: begin cmd_o.op = obc_pkg::OP_M4A; state_d = S_M5; end
      S_M5: begin
        if (!st_i.mb_nil) begin
          cmd_o.op = obc_pkg::OP_MFB;
          ret_d = S_M6; state_d = S_FRD;
        end else begin
          state_d = S_M1;
        end
      end
      S_M6: begin cmd_o.op = obc_pkg::OP_M2B; state_d = S_M7; end
      S_M7: begin
        cmd_o.op = obc_pkg::OP_M3B;
        state_d = st_i.hit ? S_MI : S_M8;
      end
      S_M8: begin cmd_o.op = obc_pkg::OP_M4B; state_d = S_M1; end
      S_MI: begin cmd_o.op = obc_pkg::OP_MI; state_d = S_MA1; end
      S_MA1: begin
        if (st_i.ia_end) begin
          state_d = S_MJ;
        end else begin
          cmd_o.op = obc_pkg::OP_PA_RD; state_d = S_MA2;
        end
      end
      S_MA2: begin
        cmd_o.op = obc_pkg::OP_PA_WR;
        state_d = st_i.pa_meet ? S_MJ : S_MA1;
      end
      S_MJ: begin cmd_o.op = obc_pkg::OP_MI; state_d = S_MB1; end
      S_MB1: begin
        if (st_i.ib_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = obc_pkg::OP_PB_RD; state_d = S_MB2;
        end
      end
      S_MB2: begin
        cmd_o.op = obc_pkg::OP_PB_WR;
        state_d = st_i.pb_meet ? S_DONE : S_MB1;
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.op = obc_pkg::OP_RESULT; state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ret_q   <= S_IDLE;
      cret_q  <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cret_q  <= cret_d;
    end
  end

endmodule

// ----- src/online_bridge_counter.sv -----
// ---------------------------------------------------------------------------
// online_bridge_counter: bridge count of a graph built one edge at a time
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   endpoint_a_i, endpoint_b_i
//   out      output     out_valid_o/out_ready_i bridge_count_o, bad_vertex_o
//   cfg      input      psel/penable/pwrite     paddr, pwdata, prdata
//
// One edge at a time, data dependent: each hop of the find walk reads the
// block-leader store (S_FRD) and then checks the registered read data
// (S_FCHK).
// After reset a clearing pass over all MAX_VERTICES store entries runs before
// the first transfer; a stamp wrap adds another pass over the stamp store.
// A waiting result does not block the next transfer in; the edge after it
// stalls at the end until the result register is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "online_bridge_counter_macros.svh"

module online_bridge_counter #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [obc_pkg::APB_AW-1:0]    paddr,
  input  logic [obc_pkg::APB_DW-1:0]    pwdata,
  output logic [obc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [obc_pkg::EP_W-1:0]      endpoint_a_i,
  input  logic [obc_pkg::EP_W-1:0]      endpoint_b_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [obc_pkg::CNT_W-1:0]     bridge_count_o,
  output logic                          bad_vertex_o
);

  localparam int VCW = obc_pkg::VC_W;
  localparam int DW  = obc_pkg::APB_DW;

  logic [VCW-1:0]   vc_q;
  obc_pkg::cmd_t    cmd;
  obc_pkg::status_t st;
  logic             sel_vc;

  assign sel_vc = (paddr[2] == obc_pkg::REG_VERTEX_COUNT);
  assign pready = 1'b1;
  assign prdata = sel_vc ? DW'(vc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= obc_pkg::VC_RESET;
    end else if (psel && penable && pwrite && pready && sel_vc) begin
      vc_q <= pwdata[VCW-1:0];
    end
  end

  obc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  obc_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .vertex_count_i (vc_q),
    .endpoint_a_i   (endpoint_a_i),
    .endpoint_b_i   (endpoint_b_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .bridge_count_o (bridge_count_o),
    .bad_vertex_o   (bad_vertex_o)
  );

  `OBC_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `OBC_ASSERT(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_o) |-> !$past(in_ready_o))
  `OBC_ASSERT(a_result_slot_free, clk_i, rst_ni, (cmd.op == obc_pkg::OP_RESULT) |-> st.out_free)
  `OBC_ASSERT_ALWAYS(a_load_on_transfer, clk_i, (cmd.op == obc_pkg::OP_LOAD) |-> (in_valid_i && in_ready_o))

endmodule

// ----- tb/online_bridge_counter_tb.sv -----
// ---------------------------------------------------------------------------
// online_bridge_counter_tb: self-checking bench for the online bridge counter
// Feeds edges with random gaps and stalls, rewrites vertex_count between
// phases and checks every bridge count against a union-find graph predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module online_bridge_counter_tb;

  localparam int NV = 1024;
  localparam int NONE = NV;
  localparam logic [obc_pkg::APB_AW-1:0] VC_ADDR = {obc_pkg::REG_VERTEX_COUNT, 2'b00};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [obc_pkg::APB_AW-1:0] paddr = '0;
  logic [obc_pkg::APB_DW-1:0] pwdata = '0;
  logic [obc_pkg::APB_DW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [obc_pkg::EP_W-1:0] endpoint_a_i = '0, endpoint_b_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [obc_pkg::CNT_W-1:0] bridge_count_o;
  logic bad_vertex_o;

  online_bridge_counter uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // graph predictor state
  int blk_lead [NV];
  int comp_lead [NV];
  int tree_up [NV];
  int comp_sz [NV];
  int unsigned seen [NV];
  int unsigned stamp;
  int unsigned bridges;
  int unsigned vc_limit;

  typedef struct packed {
    logic [obc_pkg::CNT_W-1:0] count;
    logic bad;
  } bridge_res_t;
  bridge_res_t count_q [$];

  int errors = 0;
  int hold_off = 0;
  bit long_stall = 1'b0;

  function automatic int find_blk(int v);
    int r, x, nx;
    if (v >= NONE) return NONE;
    r = v;
    while (blk_lead[r] != r) r = blk_lead[r];
    x = v;
    while (x != r) begin
      nx = blk_lead[x];
      blk_lead[x] = r;
      x = nx;
    end
    return r;
  endfunction

  function automatic int find_cmp(int v);
    int r, x, y;
    v = find_blk(v);
    r = v;
    while (comp_lead[r] != r) r = find_blk(comp_lead[r]);
    x = v;
    while (x != r && x < NONE) begin
      y = find_blk(comp_lead[x]);
      comp_lead[x] = r;
      x = y;
    end
    return r;
  endfunction

  function automatic void reroot_tree(int v);
    int root, child, p;
    child = NONE;
    v = find_blk(v);
    root = v;
    while (v < NONE) begin
      p = find_blk(tree_up[v]);
      tree_up[v] = child;
      comp_lead[v] = root;
      child = v;
      v = p;
    end
    if (child < NONE) comp_sz[root] = comp_sz[child];
  endfunction

  function automatic void close_cycle(int a, int b);
    int pa [$], pb [$];
    int meet;
    meet = NONE;
    stamp++;
    if (stamp == 0) begin
      foreach (seen[i]) seen[i] = 0;
      stamp = 1;
    end
    while (pa.size() < NV && pb.size() < NV) begin
      if (a >= NONE && b >= NONE) break;
      if (a < NONE) begin
        a = find_blk(a);
        pa.insert(pa.size(), a);
        if (seen[a] == stamp) begin meet = a; break; end
        seen[a] = stamp;
        a = tree_up[a];
      end
      if (b < NONE) begin
        b = find_blk(b);
        pb.insert(pb.size(), b);
        if (seen[b] == stamp) begin meet = b; break; end
        seen[b] = stamp;
        b = tree_up[b];
      end
    end
    if (meet >= NONE) return;
    foreach (pa[i]) begin
      blk_lead[pa[i]] = meet;
      if (pa[i] == meet) break;
      if (bridges > 0) bridges--;
    end
    foreach (pb[i]) begin
      blk_lead[pb[i]] = meet;
      if (pb[i] == meet) break;
      if (bridges > 0) bridges--;
    end
  endfunction

  function automatic void link_edge(int a, int b);
    int ca, cb, t;
    a = find_blk(a);
    b = find_blk(b);
    if (a == b) return;
    ca = find_cmp(a);
    cb = find_cmp(b);
    if (ca != cb) begin
      bridges++;
      if (comp_sz[ca] > comp_sz[cb]) begin
        t = a; a = b; b = t;
        t = ca; ca = cb; cb = t;
      end
      reroot_tree(a);
      tree_up[a] = b;
      comp_lead[a] = b;
      comp_sz[cb] += comp_sz[a];
    end else begin
      close_cycle(a, b);
    end
  endfunction

  function automatic void predict_edge(int a, int b);
    bridge_res_t r;
    int unsigned lim;
    lim = (vc_limit < NV) ? vc_limit : NV;
    r.bad = (a >= lim) || (b >= lim);
    if (!r.bad) link_edge(a, b);
    r.count = bridges[obc_pkg::CNT_W-1:0];
    count_q.insert(count_q.size(), r);
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // valid stays high between back-to-back transfers; a gap or drain drops it
  task automatic send_edge(int a, int b);
    int gap;
    gap = 0;
    if ($urandom_range(0, 3) == 0) gap = $urandom_range(0, 1) ? 30 : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    endpoint_a_i <= a[obc_pkg::EP_W-1:0];
    endpoint_b_i <= b[obc_pkg::EP_W-1:0];
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_edge(a, b);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (count_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_vertex_count(int unsigned v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= VC_ADDR; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    vc_limit = v & 32'h7FF;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (count_q.size() == 0) begin
        report("unexpected transfer", bridge_count_o, -1);
      end else begin
        if (bridge_count_o !== count_q[0].count)
          report("bridge_count", bridge_count_o, count_q[0].count);
        if (bad_vertex_o !== count_q[0].bad)
          report("bad_vertex", bad_vertex_o, count_q[0].bad);
        void'(count_q.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    if (long_stall) begin
      out_ready_i <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      hold_off = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic test_directed();
    int m;
    m = NV - 1;
    send_edge(0, 0);
    send_edge(0, 1);
    send_edge(1, 2);
    send_edge(2, 0);
    send_edge(m, 0);
    send_edge(0, m);
    send_edge(1023, 682);
    send_edge(341, 682);
    send_edge(341, 1023);
    drain();
    write_vertex_count(4);
    send_edge(3, 4);
    send_edge(4, 3);
    send_edge(1023, 0);
    send_edge(3, 2);
    drain();
    write_vertex_count(0);
    send_edge(0, 0);
    send_edge(1, 2);
    drain();
    write_vertex_count(2047);
    send_edge(1023, 1022);
    drain();
    write_vertex_count(1);
    send_edge(0, 0);
    send_edge(0, 1);
    drain();
    write_vertex_count(1024);
  endtask

  task automatic test_random(int n, int span);
    int a, b;
    repeat (n) begin
      a = $urandom_range(0, span - 1);
      case ($urandom_range(0, 9))
        0: b = $urandom_range(0, NV - 1);
        1: b = a;
        default: b = $urandom_range(0, span - 1);
      endcase
      send_edge(a, b);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        long_stall = 1'b1;
        repeat (300) @(negedge clk_i);
        long_stall = 1'b0;
      end
      test_random(12, 16);
    join
    drain();
  endtask

  initial begin
    foreach (blk_lead[i]) begin
      blk_lead[i] = i; comp_lead[i] = i; tree_up[i] = NONE; comp_sz[i] = 1; seen[i] = 0;
    end
    stamp = 0;
    bridges = 0;
    vc_limit = obc_pkg::VC_RESET;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(200, 24);
    drain();
    write_vertex_count(64);
    test_random(150, 80);
    test_backpressure();
    write_vertex_count(1024);
    test_random(250, NV);
    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- online_bridge_counter.f -----
+incdir+src
src/obc_pkg.sv
src/obc_dp.sv
src/obc_ctrl.sv
src/online_bridge_counter.sv
tb/online_bridge_counter_tb.sv
